/* src/dbat_pkg.sv */
package dbat_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  rec_kind;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [11:0] offset;
        logic [7:0]  tid;
        logic [4:0]  ver_num;
        logic        current_next;
        logic [7:0]  sect_num;
        logic [7:0]  last_sect_num;
        logic [6:0]  index;
        logic [1:0]  status;
        logic        last_record;
    } out_item_t;

    localparam logic [1:0] KIND_BQ_DESC = 2'd0;
    localparam logic [1:0] KIND_STREAM  = 2'd1;
    localparam logic [1:0] KIND_TS_DESC = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_CRC    = 2'd1;
    localparam logic [1:0] ST_LENGTH = 2'd2;

    localparam logic [1:0] REG_MAX_DESC    = 2'd0;
    localparam logic [1:0] REG_MAX_STREAMS = 2'd1;
    localparam logic [1:0] REG_MIN_LENGTH  = 2'd2;
    localparam logic [1:0] REG_MAX_LENGTH  = 2'd3;

    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

    // one byte through the mpeg-2 crc-32, msb first
    function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'd0};
        for (int k = 0; k < 8; k++) begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

/* src/dvb_bat_section_parser.sv */
// channel  | ports                        | direction | payload
// ---------+------------------------------+-----------+--------------------------
// input    | s_valid s_ready s_data       | in        | one section byte + last
// result   | m_valid m_ready m_data       | out       | one record
// config   | cfg_valid cfg_ready cfg_*    | in        | register index + data
//
// one byte per cycle while m_ready stays high; a record passes through the
// front parse register, then the record queue
// two credits cover the front register and the queue; a byte is taken when a
// credit is free or a queue slot leaves in the same cycle
// reset is synchronous active low and restores the register defaults
module dvb_bat_section_parser #(
    parameter int MAX_SECTION_BYTES = 4096,
    parameter int MAX_RECORDS       = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dbat_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dbat_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [12:0]         cfg_data
);
    import dbat_pkg::*;

    logic [6:0]  max_desc_reg, max_streams_reg;
    logic [12:0] min_len_reg, max_len_reg;
    logic        in_en, rec_valid, q_pop, q_empty_ok;
    out_item_t   rec_data;
    logic [1:0]  q_room;
    logic        in_en_d_reg;
    logic        q_valid;
    logic [$bits(out_item_t):0] q_rd;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_desc_reg    <= 7'd16;
            max_streams_reg <= 7'd64;
            min_len_reg     <= 13'd16;
            max_len_reg     <= 13'd1024;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MAX_DESC:    max_desc_reg    <= cfg_data[6:0];
                REG_MAX_STREAMS: max_streams_reg <= cfg_data[6:0];
                REG_MIN_LENGTH:  min_len_reg     <= cfg_data;
                REG_MAX_LENGTH:  max_len_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // credit: a byte may enter only if the queue has room for its record and any
    // record sitting in the front output register
    // credit returns for every slot leaving the queue, record or not
    always_ff @(posedge aclk) begin
        if (!aresetn) q_room <= 2'd2;
        else q_room <= q_room - {1'b0, in_en} + {1'b0, q_pop};
    end
    assign q_pop      = q_valid && (m_ready || !q_rd[$bits(out_item_t)]);
    assign q_empty_ok = (q_room != 2'd0);
    assign s_ready    = q_empty_ok || q_pop;
    assign in_en      = s_valid && s_ready;

    dbat_front #(
        .MAX_SECTION_BYTES(MAX_SECTION_BYTES),
        .MAX_RECORDS      (MAX_RECORDS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_data         (s_data),
        .in_en           (in_en),
        .max_descriptors (max_desc_reg),
        .max_streams     (max_streams_reg),
        .min_length      (min_len_reg),
        .max_length      (max_len_reg),
        .rec_valid       (rec_valid),
        .rec_data        (rec_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) in_en_d_reg <= 1'b0;
        else in_en_d_reg <= in_en;
    end

    // the queue also holds no-record slots, dropped at the output
    dbat_fifo #(.WIDTH($bits(out_item_t) + 1)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (in_en_d_reg),
        .wr_data  ({rec_valid, rec_data}),
        .rd_valid (q_valid),
        .rd_ready (m_ready || !q_rd[$bits(out_item_t)]),
        .rd_data  (q_rd)
    );

    assign m_valid = q_valid && q_rd[$bits(out_item_t)];
    assign m_data  = q_rd[$bits(out_item_t)-1:0];
endmodule

/* src/dbat_fifo.sv */
module dbat_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    // two-entry queue, the writer holds credits so it never writes when full
    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;
    logic             wr_ready;
    logic             wr_en, rd_en;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wp_reg] <= wr_data;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end
endmodule

/* src/dbat_front.sv */
module dbat_front #(
    parameter int MAX_SECTION_BYTES = 4096,
    parameter int MAX_RECORDS       = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dbat_pkg::in_item_t  in_data,
    input  logic                in_en,
    input  logic [6:0]          max_descriptors,
    input  logic [6:0]          max_streams,
    input  logic [12:0]         min_length,
    input  logic [12:0]         max_length,
    output logic                rec_valid,
    output dbat_pkg::out_item_t rec_data
);
    import dbat_pkg::*;

    typedef enum logic [3:0] {
        PH_HDR, PH_BQ_TAG, PH_BQ_LEN, PH_BQ_PAY, PH_BQ_REST, PH_TSL_HI, PH_TSL_LO,
        PH_TS_ENTRY, PH_TD_TAG, PH_TD_LEN, PH_TD_PAY, PH_TD_REST, PH_TS_REST, PH_TRAILER
    } phase_t;

    localparam logic [12:0] MAX_BYTES = 13'(MAX_SECTION_BYTES);
    localparam logic [6:0]  MAX_REC   = 7'(MAX_RECORDS);

    phase_t      phase_reg, phase_next;
    logic [12:0] count_reg, count_next;
    logic [31:0] crc_reg, crc_next, dly_reg, dly_next;
    logic [57:0] hdr_reg, hdr_next;
    logic [12:0] outer_reg, outer_next, inner_reg, inner_next;
    logic [7:0]  skip_reg, skip_next;
    logic [39:0] ent_reg, ent_next;
    logic [6:0]  dcnt_reg, dcnt_next, scnt_reg, scnt_next, btot_reg, btot_next;
    logic        rv_next;
    out_item_t   rd_next;
    logic [6:0]  lim_d, lim_s;
    logic [7:0]  b;
    logic [11:0] pos_m1, tdl;
    logic [12:0] len;

    assign lim_d = (max_descriptors > MAX_REC) ? MAX_REC : max_descriptors;
    assign lim_s = (max_streams > MAX_REC) ? MAX_REC : max_streams;
    assign b      = in_data.data_byte;
    assign pos_m1 = 12'(count_reg - 13'd1);
    assign tdl    = {ent_reg[3:0], b};

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        crc_next   = crc_reg;
        dly_next   = dly_reg;
        hdr_next   = hdr_reg;
        outer_next = outer_reg;
        inner_next = inner_reg;
        skip_next  = skip_reg;
        ent_next   = ent_reg;
        dcnt_next  = dcnt_reg;
        scnt_next  = scnt_reg;
        btot_next  = btot_reg;
        rv_next    = 1'b0;
        rd_next    = '0;
        len        = '0;
        if (in_en) begin
            if (count_reg < MAX_BYTES) begin
                if (count_reg >= 13'd4) crc_next = crc_step(crc_reg, dly_reg[31:24]);
                dly_next   = {dly_reg[23:0], b};
                count_next = count_reg + 13'd1;
                unique case (phase_reg)
                    PH_HDR: begin
                        case (count_reg)
                            13'd0: hdr_next[7:0]   = b;
                            13'd1: hdr_next[19:16] = b[3:0];
                            13'd2: hdr_next[15:8]  = b;
                            13'd3: hdr_next[35:28] = b;
                            13'd4: hdr_next[27:20] = b;
                            13'd5: hdr_next[41:36] = {b[0], b[5:1]};
                            13'd6: hdr_next[49:42] = b;
                            13'd7: hdr_next[57:50] = b;
                            13'd8: ent_next = {36'd0, b[3:0]};
                            default: begin
                                outer_next = {1'b0, ent_reg[3:0], b};
                                dcnt_next  = '0;
                                phase_next = ({ent_reg[3:0], b} != 12'd0) ? PH_BQ_TAG
                                                                           : PH_TSL_HI;
                            end
                        endcase
                    end
                    PH_BQ_TAG, PH_BQ_LEN, PH_BQ_PAY, PH_BQ_REST: begin
                        if (phase_reg == PH_BQ_TAG) begin
                            if (outer_reg >= 13'd2 && dcnt_reg < lim_d) begin
                                ent_next = {32'd0, b};
                                phase_next = PH_BQ_LEN;
                            end else phase_next = PH_BQ_REST;
                        end else if (phase_reg == PH_BQ_LEN) begin
                            rv_next          = 1'b1;
                            rd_next.rec_kind = KIND_BQ_DESC;
                            rd_next.word_a   = {8'd0, ent_reg[7:0]};
                            rd_next.word_b   = {8'd0, b};
                            rd_next.offset   = pos_m1;
                            rd_next.index    = dcnt_reg;
                            dcnt_next  = dcnt_reg + 7'd1;
                            btot_next  = dcnt_reg + 7'd1;
                            skip_next  = b;
                            phase_next = (b != 8'd0) ? PH_BQ_PAY : PH_BQ_TAG;
                        end else if (phase_reg == PH_BQ_PAY) begin
                            skip_next = skip_reg - 8'd1;
                            if (skip_reg == 8'd1) phase_next = PH_BQ_TAG;
                        end
                        outer_next = outer_reg - 13'd1;
                        if (outer_reg == 13'd1) phase_next = PH_TSL_HI;
                    end
                    PH_TSL_HI: begin
                        ent_next   = {36'd0, b[3:0]};
                        phase_next = PH_TSL_LO;
                    end
                    PH_TSL_LO: begin
                        outer_next = {1'b0, ent_reg[3:0], b};
                        scnt_next  = '0;
                        skip_next  = '0;
                        phase_next = ({ent_reg[3:0], b} != 12'd0) ? PH_TS_ENTRY : PH_TRAILER;
                    end
                    PH_TRAILER: ;
                    default: begin
                        // transport stream loop
                        if (phase_reg == PH_TS_ENTRY) begin
                            if (skip_reg == 8'd0 && !(outer_reg >= 13'd6 && scnt_reg < lim_s))
                                phase_next = PH_TS_REST;
                            else if (skip_reg < 8'd5) begin
                                ent_next  = {ent_reg[31:0], b};
                                skip_next = skip_reg + 8'd1;
                            end else begin
                                rv_next          = 1'b1;
                                rd_next.rec_kind = KIND_STREAM;
                                rd_next.word_a   = ent_reg[39:24];
                                rd_next.word_b   = ent_reg[23:8];
                                rd_next.offset   = tdl;
                                rd_next.index    = scnt_reg;
                                scnt_next  = scnt_reg + 7'd1;
                                dcnt_next  = '0;
                                skip_next  = '0;
                                inner_next = {1'b0, tdl};
                                phase_next = (tdl != 12'd0) ? PH_TD_TAG : PH_TS_ENTRY;
                            end
                        end else if (phase_reg != PH_TS_REST) begin
                            if (phase_reg == PH_TD_TAG) begin
                                if (inner_reg >= 13'd2 && dcnt_reg < lim_d) begin
                                    ent_next = {32'd0, b};
                                    phase_next = PH_TD_LEN;
                                end else phase_next = PH_TD_REST;
                            end else if (phase_reg == PH_TD_LEN) begin
                                rv_next          = 1'b1;
                                rd_next.rec_kind = KIND_TS_DESC;
                                rd_next.word_a   = {8'd0, ent_reg[7:0]};
                                rd_next.word_b   = {8'd0, b};
                                rd_next.offset   = pos_m1;
                                rd_next.index    = dcnt_reg;
                                dcnt_next  = dcnt_reg + 7'd1;
                                skip_next  = b;
                                phase_next = (b != 8'd0) ? PH_TD_PAY : PH_TD_TAG;
                            end else if (phase_reg == PH_TD_PAY) begin
                                skip_next = skip_reg - 8'd1;
                                if (skip_reg == 8'd1) phase_next = PH_TD_TAG;
                            end
                            inner_next = inner_reg - 13'd1;
                            if (inner_reg == 13'd1) begin
                                skip_next  = '0;
                                phase_next = PH_TS_ENTRY;
                            end
                        end
                        outer_next = outer_reg - 13'd1;
                        if (outer_reg == 13'd1) phase_next = PH_TRAILER;
                    end
                endcase
            end else begin
                count_next = MAX_BYTES + 13'd1;
            end

            if (in_data.last_byte) begin
                len = count_next;
                rv_next = 1'b1;
                rd_next = '0;
                rd_next.rec_kind      = KIND_SUMMARY;
                rd_next.word_a        = hdr_next[35:20];
                rd_next.word_b        = {4'd0, hdr_next[19:8]};
                rd_next.offset        = {5'd0, btot_next};
                rd_next.tid           = hdr_next[7:0];
                rd_next.ver_num       = hdr_next[40:36];
                rd_next.current_next  = hdr_next[41];
                rd_next.sect_num      = hdr_next[49:42];
                rd_next.last_sect_num = hdr_next[57:50];
                rd_next.index         = scnt_next;
                rd_next.last_record   = 1'b1;
                if (len < min_length || len > max_length || len > MAX_BYTES)
                    rd_next.status = ST_LENGTH;
                else if (crc_next != dly_next)
                    rd_next.status = ST_CRC;
                else
                    rd_next.status = ST_OK;
                phase_next = PH_HDR;
                count_next = '0;
                crc_next   = '1;
                dly_next   = '0;
                hdr_next   = '0;
                ent_next   = '0;
                outer_next = '0;
                inner_next = '0;
                skip_next  = '0;
                dcnt_next  = '0;
                scnt_next  = '0;
                btot_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR;
            count_reg <= '0;
            crc_reg   <= '1;
            dly_reg   <= '0;
            hdr_reg   <= '0;
            outer_reg <= '0;
            inner_reg <= '0;
            skip_reg  <= '0;
            ent_reg   <= '0;
            dcnt_reg  <= '0;
            scnt_reg  <= '0;
            btot_reg  <= '0;
            rec_valid <= 1'b0;
            rec_data  <= '0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
            dly_reg   <= dly_next;
            hdr_reg   <= hdr_next;
            outer_reg <= outer_next;
            inner_reg <= inner_next;
            skip_reg  <= skip_next;
            ent_reg   <= ent_next;
            dcnt_reg  <= dcnt_next;
            scnt_reg  <= scnt_next;
            btot_reg  <= btot_next;
            rec_valid <= rv_next;
            rec_data  <= rd_next;
        end
    end
endmodule
